>>> src/ssbm_pkg.sv
`timescale 1ns / 1ps
// package for the sorted set batch merge block
// field widths, merge status codes and control structs; no dependencies
package ssbm_pkg;

  localparam int NEW_KEY_W      = 32;
  localparam int STORED_COUNT_W = 9;
  localparam int ADDED_COUNT_W  = 5;
  localparam int MERGE_STATUS_W = 2;

  typedef enum logic [MERGE_STATUS_W-1:0] {
    ST_MERGED   = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNSORTED = 2'd2
  } merge_status_t;

  // state of the batch being collected
  typedef struct packed {
    logic unsorted;
    logic overflow;
  } batch_flags_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
  } cell_ctrl_t;

endpackage

>>> src/ssbm_in_if.sv
`timescale 1ns / 1ps
// input channel: one batch key per transaction
// depends on ssbm_pkg
interface ssbm_in_if;
  import ssbm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [NEW_KEY_W-1:0] new_key;
  logic                 last_of_batch;

  modport source (output valid, output new_key, output last_of_batch, input ready);
  modport sink   (input valid, input new_key, input last_of_batch, output ready);
endinterface

>>> src/ssbm_out_if.sv
`timescale 1ns / 1ps
// result channel: one transaction per finished batch
// depends on ssbm_pkg
interface ssbm_out_if;
  import ssbm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STORED_COUNT_W-1:0] stored_count;
  logic [ADDED_COUNT_W-1:0]  added_count;
  logic [MERGE_STATUS_W-1:0] merge_status;

  modport source (output valid, output stored_count, output added_count,
                  output merge_status, input ready);
  modport sink   (input valid, input stored_count, input added_count,
                  input merge_status, output ready);
endinterface

>>> src/ssbm_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module ssbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/ssbm_batch.sv
`timescale 1ns / 1ps
// batch collector: buffers keys in a ram, tracks fill, ordering and overflow
// depends on ssbm_pkg and ssbm_ram
module ssbm_batch #(
  parameter int BATCH_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      take,
  input  logic [KEY_BITS-1:0]                       key,
  input  logic                                      clear,
  input  logic [(BATCH_DEPTH > 1 ? $clog2(BATCH_DEPTH) : 1)-1:0] rd_addr,
  output logic [KEY_BITS-1:0]                       rd_data,
  output logic [$clog2(BATCH_DEPTH+2)-1:0]          fill,
  output ssbm_pkg::batch_flags_t                    flags
);
  import ssbm_pkg::*;

  localparam int BW = $clog2(BATCH_DEPTH + 2);
  localparam int AW = BATCH_DEPTH > 1 ? $clog2(BATCH_DEPTH) : 1;

  logic [BW-1:0]       fill_r, fill_nxt;
  logic                unsorted_r, unsorted_nxt;
  logic [KEY_BITS-1:0] prev_r, prev_nxt;
  logic                wr_en;

  always_comb begin
    fill_nxt     = fill_r;
    unsorted_nxt = unsorted_r;
    prev_nxt     = prev_r;
    wr_en        = 1'b0;
    if (clear) begin
      fill_nxt     = '0;
      unsorted_nxt = 1'b0;
    end else if (take) begin
      if (fill_r != '0 && key <= prev_r) begin
        unsorted_nxt = 1'b1;
      end
      prev_nxt = key;
      if (fill_r < BW'(BATCH_DEPTH)) begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end else begin
        // keys past the buffer are dropped, the batch is marked overflowed
        fill_nxt = BW'(BATCH_DEPTH + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      unsorted_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      unsorted_r <= unsorted_nxt;
    end
    prev_r <= prev_nxt;
  end

  ssbm_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (BATCH_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign fill           = fill_r;
  assign flags.unsorted = unsorted_r;
  assign flags.overflow = fill_r > BW'(BATCH_DEPTH);

endmodule

>>> src/ssbm_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted key chain: holds one key, passes a token onward each cycle
// depends on ssbm_pkg
module ssbm_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssbm_pkg::cell_ctrl_t ctrl,
  input  logic                 tok_valid_i,
  input  logic [KEY_BITS-1:0]  tok_key_i,
  input  logic                 tok_hit_i,
  output logic                 tok_valid_o,
  output logic [KEY_BITS-1:0]  tok_key_o,
  output logic                 tok_hit_o
);
  import ssbm_pkg::*;

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                tok_valid_r, tok_valid_nxt;
  logic [KEY_BITS-1:0] tok_key_r, tok_key_nxt;
  logic                tok_hit_r, tok_hit_nxt;

  always_comb begin
    valid_nxt     = valid_r;
    key_nxt       = key_r;
    tok_valid_nxt = tok_valid_i;
    tok_key_nxt   = tok_key_i;
    tok_hit_nxt   = tok_hit_i | (valid_r && tok_key_i == key_r);
    if (ctrl.insert && tok_valid_i) begin
      priority if (!valid_r) begin
        // first free cell takes the token
        valid_nxt     = 1'b1;
        key_nxt       = tok_key_i;
        tok_valid_nxt = 1'b0;
      end else if (tok_key_i == key_r) begin
        tok_valid_nxt = 1'b0;
      end else if (tok_key_i < key_r) begin
        // keep the smaller key, push the held one down the chain
        key_nxt     = tok_key_i;
        tok_key_nxt = key_r;
      end else begin
        // a larger token passes on untouched
        tok_key_nxt = tok_key_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      tok_valid_r <= tok_valid_nxt;
    end
    key_r     <= key_nxt;
    tok_key_r <= tok_key_nxt;
    tok_hit_r <= tok_hit_nxt;
  end

  assign tok_valid_o = tok_valid_r;
  assign tok_key_o   = tok_key_r;
  assign tok_hit_o   = tok_hit_r;

endmodule

>>> src/sorted_set_batch_merge.sv
`timescale 1ns / 1ps
// top level of the sorted set batch merge: batch collector, cell chain, sequencer
// depends on ssbm_pkg, ssbm_in_if, ssbm_out_if, ssbm_batch, ssbm_cell
//
// channel | dir | transaction
// in_ch   | in  | new_key, last_of_batch: one batch key
// out_ch  | out | stored_count, added_count, merge_status: one per batch
//
// after the last key, a batch found unsorted or too long reports from the
// check state; a merging batch runs a probe pass and an insert pass through
// the chain of STORE_DEPTH cells.
// a batch that would overflow the store is rejected right after the probe pass.
// synchronous reset empties the store and the batch at once.
// no key is taken from the last key until the batch is checked or merged, and
// a last key is also held off while the previous result waits on out_ch.
module sorted_set_batch_merge #(
  parameter int STORE_DEPTH = 256,
  parameter int BATCH_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input logic        clk,
  input logic        rst_n,
  ssbm_in_if.sink    in_ch,
  ssbm_out_if.source out_ch
);
  import ssbm_pkg::*;

  localparam int SW = $clog2(STORE_DEPTH + 1);
  localparam int BW = $clog2(BATCH_DEPTH + 2);
  localparam int AW = BATCH_DEPTH > 1 ? $clog2(BATCH_DEPTH) : 1;
  localparam int AC = $clog2(BATCH_DEPTH + 1);
  localparam int CW = $clog2(STORE_DEPTH + BATCH_DEPTH + 2);

  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_CHECK   = 4'b0010,
    S_PROBE   = 4'b0100,
    S_COMMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // key taken modulo 2^KEY_BITS
  logic [KEY_BITS-1:0] key_in;
  generate
    if (KEY_BITS > NEW_KEY_W) begin : g_key_ext
      assign key_in = {{(KEY_BITS - NEW_KEY_W){1'b0}}, in_ch.new_key};
    end else if (KEY_BITS == NEW_KEY_W) begin : g_key_eq
      assign key_in = in_ch.new_key;
    end else begin : g_key_cut
      assign key_in = in_ch.new_key[KEY_BITS-1:0];
    end
  endgenerate

  logic                take;
  logic                batch_clear;
  logic [KEY_BITS-1:0] rd_data;
  logic [BW-1:0]       bfill;
  batch_flags_t        bflags;

  logic [CW-1:0] cyc_r, cyc_nxt;
  logic [CW-1:0] cyc_end;
  logic          rd_req;
  logic          rd_v_r, rd_v_nxt;
  logic [AC-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] merged_sum;

  logic                      out_valid_r, out_valid_nxt;
  logic [STORED_COUNT_W-1:0] out_stored_r, out_stored_nxt;
  logic [ADDED_COUNT_W-1:0]  out_added_r, out_added_nxt;
  merge_status_t             out_status_r, out_status_nxt;

  logic [31:0] fill_ext;
  logic [31:0] cnt_ext;
  logic [31:0] sum_ext;

  cell_ctrl_t          cell_ctrl;
  logic                tok_v [STORE_DEPTH+1];
  logic [KEY_BITS-1:0] tok_k [STORE_DEPTH+1];
  logic                tok_h [STORE_DEPTH+1];

  assign in_ch.ready = (state_r == S_COLLECT) &&
                       (!out_valid_r || out_ch.ready || !in_ch.last_of_batch);
  assign take = in_ch.valid && in_ch.ready;

  ssbm_batch #(
    .BATCH_DEPTH (BATCH_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_batch (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .key     (key_in),
    .clear   (batch_clear),
    .rd_addr (cyc_r[AW-1:0]),
    .rd_data (rd_data),
    .fill    (bfill),
    .flags   (bflags)
  );

  // the chain: tokens enter at cell 0 in the cycle after the buffer read
  assign cell_ctrl.insert = (state_r == S_COMMIT);
  assign tok_v[0] = rd_v_r;
  assign tok_k[0] = rd_data;
  assign tok_h[0] = 1'b0;

  generate
    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      ssbm_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cell_ctrl),
        .tok_valid_i (tok_v[i]),
        .tok_key_i   (tok_k[i]),
        .tok_hit_i   (tok_h[i]),
        .tok_valid_o (tok_v[i+1]),
        .tok_key_o   (tok_k[i+1]),
        .tok_hit_o   (tok_h[i+1])
      );
    end
  endgenerate

  assign cyc_end    = CW'(bfill) + CW'(STORE_DEPTH);
  assign rd_req     = cyc_r < CW'(bfill);
  assign merged_sum = CW'(fill_r) + CW'(cnt_nxt);
  assign sum_ext    = 32'(merged_sum);

  always_comb begin
    state_nxt      = state_r;
    cyc_nxt        = cyc_r;
    rd_v_nxt       = 1'b0;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    batch_clear    = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_stored_nxt = out_stored_r;
    out_added_nxt  = out_added_r;
    out_status_nxt = out_status_r;
    fill_ext       = 32'(fill_r);
    cnt_ext        = 32'(cnt_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_COLLECT: begin
        if (take && in_ch.last_of_batch) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cyc_nxt = '0;
        cnt_nxt = '0;
        priority if (bflags.unsorted) begin
          out_valid_nxt  = 1'b1;
          out_stored_nxt = fill_ext[STORED_COUNT_W-1:0];
          out_added_nxt  = '0;
          out_status_nxt = ST_UNSORTED;
          batch_clear    = 1'b1;
          state_nxt      = S_COLLECT;
        end else if (bflags.overflow) begin
          out_valid_nxt  = 1'b1;
          out_stored_nxt = fill_ext[STORED_COUNT_W-1:0];
          out_added_nxt  = '0;
          out_status_nxt = ST_FULL;
          batch_clear    = 1'b1;
          state_nxt      = S_COLLECT;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        rd_v_nxt = rd_req;
        cyc_nxt  = cyc_r + 1'b1;
        // a token leaving the chain without a match is a new key
        if (tok_v[STORE_DEPTH] && !tok_h[STORE_DEPTH]) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cyc_r == cyc_end) begin
          cyc_nxt = '0;
          if (merged_sum > CW'(STORE_DEPTH)) begin
            out_valid_nxt  = 1'b1;
            out_stored_nxt = fill_ext[STORED_COUNT_W-1:0];
            out_added_nxt  = '0;
            out_status_nxt = ST_FULL;
            batch_clear    = 1'b1;
            state_nxt      = S_COLLECT;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        rd_v_nxt = rd_req;
        cyc_nxt  = cyc_r + 1'b1;
        if (cyc_r == cyc_end) begin
          fill_nxt       = SW'(merged_sum);
          out_valid_nxt  = 1'b1;
          out_stored_nxt = sum_ext[STORED_COUNT_W-1:0];
          out_added_nxt  = cnt_ext[ADDED_COUNT_W-1:0];
          out_status_nxt = ST_MERGED;
          batch_clear    = 1'b1;
          state_nxt      = S_COLLECT;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      rd_v_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cyc_r        <= cyc_nxt;
    cnt_r        <= cnt_nxt;
    out_stored_r <= out_stored_nxt;
    out_added_r  <= out_added_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.stored_count = out_stored_r;
  assign out_ch.added_count  = out_added_r;
  assign out_ch.merge_status = out_status_r;

endmodule

>>> sim/tb_sorted_set_batch_merge.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_set_batch_merge: directed and random key batches
// depends on ssbm_pkg, ssbm_in_if, ssbm_out_if and the sorted_set_batch_merge rtl
module tb_sorted_set_batch_merge;
  import ssbm_pkg::*;

  localparam int STORE_DEPTH   = 256;
  localparam int BATCH_DEPTH   = 16;
  localparam int KEY_BITS      = 32;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int IDLE_PCT      = 17;
  localparam int SETTLE_CYCLES = 2 * (BATCH_DEPTH + STORE_DEPTH) + 16;
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef logic [NEW_KEY_W-1:0] key_t;
  typedef key_t key_q_t[$];

  typedef struct packed {
    logic [STORED_COUNT_W-1:0] stored;
    logic [ADDED_COUNT_W-1:0]  added;
    merge_status_t             status;
  } merge_result_t;

  logic clk;
  logic rst_n;

  ssbm_in_if  in_ch();
  ssbm_out_if out_ch();

  sorted_set_batch_merge #(
    .STORE_DEPTH(STORE_DEPTH),
    .BATCH_DEPTH(BATCH_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the key set and the batch under collection
  key_t key_set[STORE_DEPTH];
  key_t merge_buf[STORE_DEPTH];
  int   set_fill;
  key_t batch_keys[BATCH_DEPTH];
  int   batch_len;
  bit   batch_bad_order;
  key_t prev_key;

  merge_result_t pending_results[$];

  bit     no_idle;
  int     items_sent;
  int     mismatch_count;
  int     merged_count;
  int     full_count;
  int     unsorted_count;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // feed one key into the shadow set, queue the merge result on a last key
  task automatic shadow_take_key(input key_t key, input logic last);
    merge_result_t r;
    int   i;
    int   j;
    int   n;
    bit   over;
    key_t v;
    if (batch_len > 0 && key <= prev_key) batch_bad_order = 1'b1;
    prev_key = key;
    if (batch_len < BATCH_DEPTH) begin
      batch_keys[batch_len] = key;
      batch_len++;
    end else begin
      batch_len = BATCH_DEPTH + 1;
    end
    if (last) begin
      r.added = '0;
      if (batch_bad_order) begin
        r.status = ST_UNSORTED;
        unsorted_count++;
      end else if (batch_len > BATCH_DEPTH) begin
        r.status = ST_FULL;
        full_count++;
      end else begin
        i = 0;
        j = 0;
        n = 0;
        over = 1'b0;
        while ((i < set_fill || j < batch_len) && !over) begin
          if (j >= batch_len || (i < set_fill && key_set[i] < batch_keys[j])) begin
            v = key_set[i];
            i++;
          end else if (i >= set_fill || batch_keys[j] < key_set[i]) begin
            v = batch_keys[j];
            j++;
          end else begin
            v = batch_keys[j];
            j++;
            i++;
          end
          if (n >= STORE_DEPTH) begin
            over = 1'b1;
          end else begin
            merge_buf[n] = v;
            n++;
          end
        end
        if (over) begin
          r.status = ST_FULL;
          full_count++;
        end else begin
          for (int k = 0; k < n; k++) key_set[k] = merge_buf[k];
          r.added  = ADDED_COUNT_W'(n - set_fill);
          set_fill = n;
          r.status = ST_MERGED;
          merged_count++;
        end
      end
      r.stored = STORED_COUNT_W'(set_fill);
      batch_len = 0;
      batch_bad_order = 1'b0;
      pending_results.push_back(r);
    end
  endtask

  task automatic send_key(input key_t key, input logic last);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.new_key       = key;
    in_ch.last_of_batch = last;
    do @(posedge clk); while (!in_ch.ready);
    shadow_take_key(key, last);
    items_sent++;
  endtask

  task automatic send_batch(input key_q_t keys);
    for (int k = 0; k < keys.size(); k++) send_key(keys[k], k == keys.size() - 1);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_key_sorted(ref key_q_t q, input key_t k);
    int pos;
    pos = 0;
    while (pos < q.size() && q[pos] < k) pos++;
    if (pos < q.size() && q[pos] == k) return;
    q.insert(pos, k);
  endfunction

  function automatic bit key_is_stored(input key_t k);
    for (int i = 0; i < set_fill; i++) if (key_set[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // mix of extremes, stored keys, their neighbors and fresh keys
  function automatic key_t pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (set_fill == STORE_DEPTH && $urandom_range(0, 4) != 0) sel = 7;
    if (set_fill == 0 && sel >= 7) sel = 2;
    case (sel)
      0: return '0;
      1: return '1;
      2, 3, 4: return key_t'($urandom);
      5, 6: return key_t'($urandom_range(0, 1023));
      7, 8: return key_set[$urandom_range(0, set_fill - 1)];
      default: return key_set[$urandom_range(0, set_fill - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  function automatic key_q_t build_ascending(input int n);
    key_q_t q;
    int tries;
    tries = 0;
    while (q.size() < n && tries < 8 * n) begin
      add_key_sorted(q, pick_key());
      tries++;
    end
    return q;
  endfunction

  // break the order at position p: either repeat the key before it or swap the pair
  function automatic void break_order(ref key_q_t q, input int p);
    key_t t;
    if ($urandom_range(0, 1)) begin
      q[p] = q[p-1];
    end else begin
      t = q[p];
      q[p] = q[p-1];
      q[p-1] = t;
    end
  endfunction

  task automatic test_single_key();
    key_q_t q;
    q = '{32'h8000_0000};
    send_batch(q);
  endtask

  task automatic test_key_extremes();
    key_q_t q;
    q = '{32'h0000_0000, 32'hFFFF_FFFF};
    send_batch(q);
  endtask

  task automatic test_duplicates();
    key_q_t q;
    q = '{32'h0000_0000, 32'h0000_0005, 32'h8000_0000};
    send_batch(q);
  endtask

  task automatic test_not_ascending();
    key_q_t q;
    wait_drain();
    q = '{32'h0000_0007, 32'h0000_0007};
    send_batch(q);
    q = '{32'h0000_0009, 32'h0000_0003, 32'h0000_000A};
    send_batch(q);
  endtask

  task automatic test_batch_too_long();
    key_q_t q;
    for (int k = 0; k <= BATCH_DEPTH; k++) q.push_back(key_t'(1000 + 100 * k));
    send_batch(q);
  endtask

  task automatic test_random_batches();
    key_q_t q;
    int kind;
    int n;
    int start;
    int batch_idx;
    start = items_sent;
    batch_idx = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_idle = (batch_idx >= 40 && batch_idx < 70);
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        q = build_ascending($urandom_range(2, BATCH_DEPTH));
        if (q.size() >= 2) break_order(q, $urandom_range(1, q.size() - 1));
      end else if (kind < 17) begin
        q = build_ascending($urandom_range(BATCH_DEPTH + 1, BATCH_DEPTH + 4));
      end else if (kind < 20) begin
        q = build_ascending($urandom_range(BATCH_DEPTH + 1, BATCH_DEPTH + 4));
        // half the time the bad key is one that gets dropped
        if (q.size() > BATCH_DEPTH && $urandom_range(0, 1))
          break_order(q, $urandom_range(BATCH_DEPTH, q.size() - 1));
        else if (q.size() >= 2)
          break_order(q, $urandom_range(1, q.size() - 1));
      end else begin
        case ($urandom_range(0, 7))
          0: n = 1;
          1: n = BATCH_DEPTH;
          default: n = $urandom_range(1, BATCH_DEPTH);
        endcase
        q = build_ascending(n);
      end
      send_batch(q);
      if ($urandom_range(0, 19) == 0) wait_drain();
      batch_idx++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_store_full();
    key_q_t q;
    int n;
    key_t k;
    wait_drain();
    while (set_fill < STORE_DEPTH) begin
      n = STORE_DEPTH - set_fill;
      if (n > BATCH_DEPTH) n = BATCH_DEPTH;
      q.delete();
      while (q.size() < n) begin
        k = key_t'($urandom);
        if (!key_is_stored(k)) add_key_sorted(q, k);
      end
      send_batch(q);
    end
    // one fresh key among stored ones overflows the store
    q.delete();
    for (int i = 0; i < 4; i++) add_key_sorted(q, key_set[$urandom_range(0, STORE_DEPTH - 1)]);
    do k = key_t'($urandom); while (key_is_stored(k));
    add_key_sorted(q, k);
    send_batch(q);
    // only stored keys still merge
    q.delete();
    for (int i = 0; i < BATCH_DEPTH; i++)
      add_key_sorted(q, key_set[$urandom_range(0, STORE_DEPTH - 1)]);
    send_batch(q);
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    merge_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, stored %0d added %0d status %0d", $time,
                 out_ch.stored_count, out_ch.added_count, out_ch.merge_status);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("stored_count", exp_r.stored, out_ch.stored_count);
        check_field("added_count", exp_r.added, out_ch.added_count);
        check_field("merge_status", exp_r.status, out_ch.merge_status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.new_key       = '0;
    in_ch.last_of_batch = 1'b0;
    out_ch.ready        = 1'b0;
    no_idle             = 1'b0;
    cycle_count         = 0;
    items_sent          = 0;
    mismatch_count      = 0;
    merged_count        = 0;
    full_count          = 0;
    unsorted_count      = 0;
    set_fill            = 0;
    batch_len           = 0;
    batch_bad_order     = 1'b0;
    prev_key            = '0;
    rst_n               = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_key();
    test_key_extremes();
    test_duplicates();
    test_not_ascending();
    test_batch_too_long();
    test_random_batches();
    test_store_full();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d keys in %0d batches; final store holds %0d keys", items_sent,
             merged_count + full_count + unsorted_count, set_fill);
    $display("batches merged %0d, rejected as full or too long %0d, rejected unsorted %0d",
             merged_count, full_count, unsorted_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
